// ===== design/ctc_pkg.sv =====
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types, constants and calendar helper functions for the calendar
// time counter.
// ----------------------------------------------------------------------------
`default_nettype none

package ctc_pkg;

	// Operation codes of an input item.
	localparam logic [1:0] OP_TICK_US = 2'd0;
	localparam logic [1:0] OP_TICK_MS = 2'd1;
	localparam logic [1:0] OP_ADD_MS  = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	// Last legal value of each fixed-range counter.
	localparam logic [9:0]  US_TOP    = 10'd999;
	localparam logic [9:0]  MS_TOP    = 10'd999;
	localparam logic [5:0]  SEC_TOP   = 6'd59;
	localparam logic [5:0]  MIN_TOP   = 6'd59;
	localparam logic [4:0]  HOUR_TOP  = 5'd23;
	localparam logic [3:0]  MONTH_TOP = 4'd12;
	localparam logic [6:0]  YEAR_TOP  = 7'd99;
	localparam logic [6:0]  CENT_TOP  = 7'd99;

	localparam logic [10:0] MS_PER_SEC = 11'd1000;

	// Reset values of the counters.
	localparam logic [9:0]  US_RST    = 10'd0;
	localparam logic [9:0]  MS_RST    = 10'd0;
	localparam logic [5:0]  SEC_RST   = 6'd10;
	localparam logic [5:0]  MIN_RST   = 6'd0;
	localparam logic [4:0]  HOUR_RST  = 5'd14;
	localparam logic [4:0]  DAY_RST   = 5'd13;
	localparam logic [3:0]  MONTH_RST = 4'd10;
	localparam logic [6:0]  YEAR_RST  = 7'd17;
	localparam logic [6:0]  CENT_RST  = 7'd20;
	localparam logic [15:0] MILL_RST  = 16'd0;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic tick_us;
		logic tick_ms;
		logic load_acc;
		logic step_sec;
		logic finish_add;
		logic copy_out;
	} ctc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic acc_ge_sec;
	} ctc_status_t;

	// Gregorian leap rule on century*100+year. Since 100 is a multiple of
	// four, divisibility by four depends on the year digits alone; a full
	// year is a multiple of 100 exactly when the year digits are zero, and
	// then it is a multiple of 400 exactly when the century is a multiple
	// of four.
	function automatic logic is_leap(input logic [6:0] year, input logic [6:0] cent);
		logic year_zero;
		year_zero = (year == 7'd0);
		return ((year[1:0] == 2'b00) && !year_zero) || (year_zero && (cent[1:0] == 2'b00));
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month)
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2:                    len = leap ? 5'd29 : 5'd28;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

	// True when a century count in the range 0 to 99 is a multiple of ten.
	function automatic logic is_decade(input logic [6:0] cent);
		return cent inside {7'd0, 7'd10, 7'd20, 7'd30, 7'd40,
			7'd50, 7'd60, 7'd70, 7'd80, 7'd90};
	endfunction

endpackage

`default_nettype wire

// ===== design/ctc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctc_ctrl
// Controller of the calendar time counter: input and output handshakes, the
// bulk-add loop and the hand-over of a finished result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_ctrl
	import ctc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire ctc_status_t status,
	output ctc_cmd_t         cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_ADD  = 1'b1;

	logic state_q;
	logic state_d;
	logic pend_q;
	logic pend_d;
	logic out_valid_q;
	logic out_valid_d;
	logic copy_ok;
	logic accept;

	// The counters hold a result (pend_q) that moves into the output register
	// once that register is empty or being emptied.
	assign copy_ok  = pend_q && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_IDLE) && (!pend_q || copy_ok);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd          = '0;
		cmd.copy_out = copy_ok;
		state_d      = state_q;
		pend_d       = pend_q && !copy_ok;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_TICK_US: begin
							cmd.tick_us = 1'b1;
							pend_d      = 1'b1;
						end
						OP_TICK_MS: begin
							cmd.tick_ms = 1'b1;
							pend_d      = 1'b1;
						end
						OP_ADD_MS: begin
							cmd.load_acc = 1'b1;
							state_d      = ST_ADD;
						end
						default: begin
							pend_d = 1'b1;
						end
					endcase
				end
			end
			ST_ADD: begin
				if (status.acc_ge_sec) begin
					cmd.step_sec = 1'b1;
				end else begin
					cmd.finish_add = 1'b1;
					pend_d         = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (copy_ok) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pend_q      <= pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== design/ctc_datapath.sv =====
// ----------------------------------------------------------------------------
// ctc_datapath
// Counter chain, millisecond accumulator for bulk adds and the output register
// of the calendar time counter.
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_datapath
	import ctc_pkg::*;
#(
	parameter int ADD_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctc_cmd_t    cmd,
	output ctc_status_t      status,
	input  wire logic [15:0] ms_count,
	output logic [9:0]       micros,
	output logic [9:0]       millis,
	output logic [5:0]       secs,
	output logic [5:0]       mins,
	output logic [4:0]       hours,
	output logic [4:0]       day_of_month,
	output logic [3:0]       month_num,
	output logic [6:0]       year_in_century,
	output logic [6:0]       century_count,
	output logic [15:0]      millennium_count
);

	localparam int USE_W = (ADD_WIDTH < 16) ? ADD_WIDTH : 16;
	localparam int ACC_W = $clog2((1 << USE_W) + 999);

	logic [9:0]       us_q;
	logic [9:0]       ms_q;
	logic [5:0]       sec_q;
	logic [5:0]       min_q;
	logic [4:0]       hour_q;
	logic [4:0]       day_q;
	logic [3:0]       month_q;
	logic [6:0]       year_q;
	logic [6:0]       cent_q;
	logic [15:0]      mill_q;
	logic [ACC_W-1:0] acc_q;

	logic       tick_ms_w;
	logic       tick_sec_w;
	logic       tick_min_w;
	logic       tick_hour_w;
	logic       tick_day_w;
	logic       tick_month_w;
	logic       tick_year_w;
	logic       tick_cent_w;
	logic       tick_mill_w;
	logic [6:0] cent_nx;
	logic [4:0] mlen;

	// Ripple carry through the chain; each stage up to the year passes a tick
	// on when it sits at its last value, the century when it steps to a decade.
	assign tick_ms_w    = cmd.tick_ms || (cmd.tick_us && (us_q >= US_TOP));
	assign tick_sec_w   = cmd.step_sec || (tick_ms_w && (ms_q >= MS_TOP));
	assign tick_min_w   = tick_sec_w && (sec_q >= SEC_TOP);
	assign tick_hour_w  = tick_min_w && (min_q >= MIN_TOP);
	assign tick_day_w   = tick_hour_w && (hour_q >= HOUR_TOP);
	assign mlen         = month_len(month_q, is_leap(year_q, cent_q));
	assign tick_month_w = tick_day_w && (day_q >= mlen);
	assign tick_year_w  = tick_month_w && (month_q >= MONTH_TOP);
	assign tick_cent_w  = tick_year_w && (year_q >= YEAR_TOP);
	assign cent_nx      = (cent_q >= CENT_TOP) ? 7'd0 : cent_q + 7'd1;
	assign tick_mill_w  = tick_cent_w && is_decade(cent_nx);

	assign status.acc_ge_sec = (acc_q >= ACC_W'(MS_PER_SEC));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			us_q    <= US_RST;
			ms_q    <= MS_RST;
			sec_q   <= SEC_RST;
			min_q   <= MIN_RST;
			hour_q  <= HOUR_RST;
			day_q   <= DAY_RST;
			month_q <= MONTH_RST;
			year_q  <= YEAR_RST;
			cent_q  <= CENT_RST;
			mill_q  <= MILL_RST;
		end else begin
			if (cmd.tick_us) begin
				us_q <= (us_q >= US_TOP) ? 10'd0 : us_q + 10'd1;
			end
			if (cmd.finish_add) begin
				ms_q <= acc_q[9:0];
			end else if (tick_ms_w) begin
				ms_q <= (ms_q >= MS_TOP) ? 10'd0 : ms_q + 10'd1;
			end
			if (tick_sec_w) begin
				sec_q <= (sec_q >= SEC_TOP) ? 6'd0 : sec_q + 6'd1;
			end
			if (tick_min_w) begin
				min_q <= (min_q >= MIN_TOP) ? 6'd0 : min_q + 6'd1;
			end
			if (tick_hour_w) begin
				hour_q <= (hour_q >= HOUR_TOP) ? 5'd0 : hour_q + 5'd1;
			end
			if (tick_day_w) begin
				day_q <= (day_q >= mlen) ? 5'd1 : day_q + 5'd1;
			end
			if (tick_month_w) begin
				month_q <= (month_q >= MONTH_TOP) ? 4'd1 : month_q + 4'd1;
			end
			if (tick_year_w) begin
				year_q <= (year_q >= YEAR_TOP) ? 7'd0 : year_q + 7'd1;
			end
			if (tick_cent_w) begin
				cent_q <= cent_nx;
			end
			if (tick_mill_w) begin
				mill_q <= mill_q + 16'd1;
			end
		end
	end

	// Bulk add: the accumulator takes the millisecond sum and gives up one
	// thousand for every second carried into the chain.
	always_ff @(posedge clk) begin
		if (cmd.load_acc) begin
			acc_q <= ACC_W'(ms_q) + ACC_W'(ms_count[USE_W-1:0]);
		end else if (cmd.step_sec) begin
			acc_q <= acc_q - ACC_W'(MS_PER_SEC);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.copy_out) begin
			micros           <= us_q;
			millis           <= ms_q;
			secs             <= sec_q;
			mins             <= min_q;
			hours            <= hour_q;
			day_of_month     <= day_q;
			month_num        <= month_q;
			year_in_century  <= year_q;
			century_count    <= cent_q;
			millennium_count <= mill_q;
		end
	end

endmodule

`default_nettype wire

// ===== design/calendar_time_counter.sv =====
// ----------------------------------------------------------------------------
// calendar_time_counter
// Calendar clock counter chain from microseconds up to millennia, driven by
// tick and bulk millisecond-add operations.
// ----------------------------------------------------------------------------
// Usage. Each input transfer (in_valid with in_ready) carries an opcode: tick
// one microsecond, tick one millisecond, add ms_count milliseconds, or the
// unused code, which leaves the time as it is. Every input transfer yields
// exactly one output transfer (out_valid with out_ready) holding all counters
// after the update.
// Ticks and the unused code are taken at one item per cycle while the output
// side keeps up; each result is registered in the counters and then moves
// into the output register.
// An add first loads the accumulator, then gives up one second at a time,
// each of which ripples through the chain, and finally makes the remainder
// the new millisecond count. in_ready is low from the cycle after the
// transfer until the add has finished.
// Reset (arst_n low) sets the time to 14:00:10.000000 on day 13 of month 10,
// year 17 of century 20, millennium 0, and empties the output register.
// When the receiver stalls, the output register holds its result; one more
// item may finish into the counters, after which in_ready stays low until
// the output register is freed.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_time_counter
	import ctc_pkg::*;
#(
	parameter int ADD_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [15:0] ms_count,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [9:0]       micros,
	output logic [9:0]       millis,
	output logic [5:0]       secs,
	output logic [5:0]       mins,
	output logic [4:0]       hours,
	output logic [4:0]       day_of_month,
	output logic [3:0]       month_num,
	output logic [6:0]       year_in_century,
	output logic [6:0]       century_count,
	output logic [15:0]      millennium_count
);

	// Commands and status are the only connection between the two halves.
	ctc_cmd_t    cmd;
	ctc_status_t status;

	// The controller sequences transfers and the bulk-add loop.
	ctc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the counters, the accumulator and the output register.
	ctc_datapath #(
		.ADD_WIDTH (ADD_WIDTH)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.ms_count         (ms_count),
		.micros           (micros),
		.millis           (millis),
		.secs             (secs),
		.mins             (mins),
		.hours            (hours),
		.day_of_month     (day_of_month),
		.month_num        (month_num),
		.year_in_century  (year_in_century),
		.century_count    (century_count),
		.millennium_count (millennium_count)
	);

endmodule

`default_nettype wire

// ===== design/ctc_checker.sv =====
// ----------------------------------------------------------------------------
// ctc_checker
// Port-level checks for the calendar time counter, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_checker
	import ctc_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  opcode,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [9:0]  micros,
	input wire logic [9:0]  millis,
	input wire logic [5:0]  secs,
	input wire logic [5:0]  mins,
	input wire logic [4:0]  hours,
	input wire logic [4:0]  day_of_month,
	input wire logic [3:0]  month_num,
	input wire logic [15:0] millennium_count
);

	// A stalled result stays valid and keeps its microsecond, millisecond and millennium fields.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(micros) && $stable(millis)
			&& $stable(millennium_count))
		else $error("result changed while stalled");

	// Every delivered time has micros through hours and the month in range, and a day of at least one.
	a_out_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (micros <= 10'd999) && (millis <= 10'd999) && (secs <= 6'd59)
			&& (mins <= 6'd59) && (hours <= 5'd23) && (day_of_month >= 5'd1)
			&& (month_num >= 4'd1) && (month_num <= 4'd12))
		else $error("result out of calendar range");

	// Once a bulk add is taken, in_ready drops as it enters the carry loop.
	a_add_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode == OP_ADD_MS) |=> !in_ready)
		else $error("input taken during a bulk add");

endmodule

bind calendar_time_counter ctc_checker u_ctc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.opcode           (opcode),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.micros           (micros),
	.millis           (millis),
	.secs             (secs),
	.mins             (mins),
	.hours            (hours),
	.day_of_month     (day_of_month),
	.month_num        (month_num),
	.millennium_count (millennium_count)
);

`default_nettype wire
